FILE: src/esc_pkg.sv
// esc_pkg: shared types, register indexes and field widths for the
// environmental sensor compensation block. No dependencies.
package esc_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 64;
    localparam int unsigned QDepth   = 4;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_TEMP    = 3'd0,
        CFG_PRESS_A = 3'd1,
        CFG_PRESS_B = 3'd2,
        CFG_HUM_A   = 3'd3,
        CFG_HUM_B   = 3'd4
    } t_cfg_idx;

    // Back-part sequencer steps: M* pressure products, DIV* the division,
    // N* the pressure correction, H* the humidity products.
    typedef enum logic [4:0] {
        S_IDLE, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_DIV0, S_DIV,
        S_N1, S_N2, S_N3, S_N4, S_H1, S_H2, S_H3, S_H4, S_H5, S_H6, S_H7, S_H8,
        S_H9, S_OUT
    } t_seq;

    typedef struct packed {
        logic [15:0] raw_hum;
        logic [19:0] raw_press;
        logic [19:0] raw_temp;
    } t_in_req;

    typedef struct packed {
        logic [16:0]        hum_q10;
        logic               press_valid;
        logic [31:0]        press_q8;
        logic signed [15:0] temp_centi;
    } t_out_req;

    // Front-to-back request: the raw pressure and humidity codes plus the fine temperature.
    typedef struct packed {
        logic [31:0] t_fine;
        logic [19:0] raw_press;
        logic [15:0] raw_hum;
    } t_mid_req;

    typedef struct packed {
        logic [47:0] temp;
        logic [63:0] press_a;
        logic [63:0] press_b;
        logic [47:0] hum_a;
        logic [31:0] hum_b;
    } t_coeffs;

endpackage

FILE: src/esc_front.sv
// esc_front: accepts raw measurement requests and forms the fine temperature
// in a short pipeline. Depends on esc_pkg.
module esc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  esc_pkg::t_in_req    i_req,
    input  logic [47:0]         i_temp_coeffs,
    output logic                o_valid,
    input  logic                i_ready,
    output esc_pkg::t_mid_req   o_req
);
    // Stage 1: products, stage 2: the last product and the sum.
    logic               r_v1, r_v2;
    logic [31:0]        r_p1, r_p2;
    logic [15:0]        r_hum1;
    logic [19:0]        r_press1;
    logic signed [31:0] r_t3;
    esc_pkg::t_mid_req  r_out;
    logic               adv2, adv1;

    logic [31:0] t1, t2, a, b, bb;
    assign t1 = {16'd0, i_temp_coeffs[15:0]};
    assign t2 = {{16{i_temp_coeffs[31]}}, i_temp_coeffs[31:16]};
    assign a  = {15'd0, i_req.raw_temp[19:3]} - (t1 << 1);
    assign b  = {16'd0, i_req.raw_temp[19:4]} - t1;
    assign bb = b * b;

    logic [31:0] v2;
    assign v2 = 32'($signed(32'($signed(r_p2) * r_t3)) >>> 14);

    assign adv2    = !r_v2 || i_ready;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_v2;
    assign o_req   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
        end
        if (adv1) begin
            r_p1     <= 32'($signed(32'(a * t2)) >>> 11);
            r_p2     <= 32'($signed(bb) >>> 12);
            r_t3     <= {{16{i_temp_coeffs[47]}}, i_temp_coeffs[47:32]};
            r_hum1   <= i_req.raw_hum;
            r_press1 <= i_req.raw_press;
        end
        if (adv2) begin
            r_out.t_fine    <= r_p1 + v2;
            r_out.raw_press <= r_press1;
            r_out.raw_hum   <= r_hum1;
        end
    end
endmodule

FILE: src/esc_fifo.sv
// esc_fifo: small request queue between the front and back parts.
// Depends on esc_pkg.
module esc_fifo #(
    parameter int unsigned Depth = esc_pkg::QDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  esc_pkg::t_mid_req i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output esc_pkg::t_mid_req o_req
);
    localparam int unsigned AW = $clog2(Depth);
    esc_pkg::t_mid_req r_mem [Depth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != (AW+1)'(Depth);
    assign o_valid = r_cnt != '0;
    assign o_req   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(Depth-1)) ? '0 : r_wp + 1'b1;
            if (pop)  r_rp <= (r_rp == AW'(Depth-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
        if (push) r_mem[r_wp] <= i_req;
    end
endmodule

FILE: src/esc_div.sv
// esc_div: 64-bit signed radix-2 restoring divider, one quotient bit per cycle.
// Truncates toward zero. No package dependency.
module esc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo
);
    logic        r_busy, r_neg;
    logic [6:0]  r_cnt;
    logic [63:0] r_q, r_d;
    logic [64:0] r_r;
    logic [64:0] sh, df;

    assign sh = {r_r[63:0], r_q[63]};
    assign df = sh - {1'b0, r_d};
    assign o_done = r_busy && r_cnt == 7'd0;
    assign o_quo  = r_neg ? 64'(0 - r_q) : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd64;
        end else if (r_busy) begin
            if (r_cnt == 7'd0) r_busy <= 1'b0;
            else r_cnt <= r_cnt - 1'b1;
        end
        if (i_start) begin
            r_q   <= i_num[63] ? 64'(0 - i_num) : i_num;
            r_d   <= i_den[63] ? 64'(0 - i_den) : i_den;
            r_neg <= i_num[63] ^ i_den[63];
            r_r   <= '0;
        end else if (r_busy && r_cnt != 7'd0) begin
            if (!df[64]) begin
                r_r <= df;
                r_q <= {r_q[62:0], 1'b1};
            end else begin
                r_r <= sh;
                r_q <= {r_q[62:0], 1'b0};
            end
        end
    end
endmodule

FILE: src/esc_back.sv
// esc_back: temperature, pressure and humidity compensation; the sequenced
// products share one 64x64 product unit cut into 32x32 partial products, with a divider.
// Depends on esc_pkg and esc_div.
module esc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  esc_pkg::t_mid_req i_req,
    input  esc_pkg::t_coeffs  i_cf,
    output logic              o_valid,
    input  logic              i_ready,
    output esc_pkg::t_out_req o_req
);
    // Microprogram: each product step loads operands into the multiplier, which then
    // adds the low-by-low, high-by-low and low-by-high 32x32 partial products in turn;
    // the high-by-high product falls outside the low 64 bits and is not added.
    esc_pkg::t_seq r_st, n_st;
    logic [63:0] r_ma, r_mb, r_acc;
    logic [1:0]  r_mph;
    logic        r_mbusy;
    logic [63:0] r_w1, r_w2, r_ww, r_p, r_q, r_x1;
    logic [31:0] r_tf, r_hv, r_x, r_y, r_z, r_r;
    logic [19:0] r_adp;
    logic [15:0] r_adh;
    esc_pkg::t_out_req r_out;
    logic r_ov;

    logic [31:0] pa, pb;
    logic [63:0] pp;
    assign pa = r_mph[0] ? r_ma[63:32] : r_ma[31:0];
    assign pb = r_mph[1] ? r_mb[63:32] : r_mb[31:0];
    assign pp = pa * pb;

    logic mdone;
    assign mdone = r_mbusy && r_mph == 2'd3;
    logic [63:0] prod;
    always_comb begin
        if (r_mph == 2'd3) prod = r_acc;
        else prod = r_acc + {pp[31:0], 32'd0};
    end

    logic        dstart, ddone;
    logic [63:0] dquo;
    esc_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dstart),
        .i_num(r_ww), .i_den(r_w1), .o_done(ddone), .o_quo(dquo)
    );

    function automatic logic [63:0] sx16(input logic [15:0] v);
        sx16 = {{48{v[15]}}, v};
    endfunction
    function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned n);
        asr64 = 64'($signed(v) >>> n);
    endfunction
    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
        asr32 = 32'($signed(v) >>> n);
    endfunction

    logic [63:0] p4x, p7x;
    assign p4x = sx16(i_cf.press_a[63:48]);
    assign p7x = sx16(i_cf.press_b[47:32]);

    logic [63:0] tfs, tcx;
    assign tfs = {{32{r_tf[31]}}, r_tf};
    assign tcx = asr64(64'(tfs * 64'd5) + 64'd128, 8);
    logic signed [15:0] tsat;
    always_comb begin
        if ($signed(tcx) > 64'sd32767) tsat = 16'sh7fff;
        else if ($signed(tcx) < -64'sd32768) tsat = 16'sh8000;
        else tsat = tcx[15:0];
    end

    logic [31:0] hv_fin;
    logic [16:0] hq;
    assign hv_fin = r_hv - asr32(32'(asr32(r_r, 7) * {24'd0, i_cf.hum_a[23:16]}), 4);
    always_comb begin
        if (hv_fin[31]) hq = '0;
        else if (hv_fin > 32'd419430400) hq = 17'd102400;
        else hq = hv_fin[28:12];
    end

    assign o_ready = (r_st == esc_pkg::S_IDLE);
    assign o_valid = r_ov;
    assign o_req   = r_out;

    logic mstart;
    logic [63:0] ma, mb;
    logic [31:0] v;
    assign v = r_tf - 32'd76800;

    // Next-state logic.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            esc_pkg::S_IDLE: if (i_valid) n_st = esc_pkg::S_M1;
            esc_pkg::S_M1, esc_pkg::S_M2, esc_pkg::S_M3, esc_pkg::S_M4,
            esc_pkg::S_M5, esc_pkg::S_M6, esc_pkg::S_M7, esc_pkg::S_N1,
            esc_pkg::S_N2, esc_pkg::S_N3, esc_pkg::S_H1, esc_pkg::S_H2,
            esc_pkg::S_H3, esc_pkg::S_H4, esc_pkg::S_H5, esc_pkg::S_H6,
            esc_pkg::S_H7:
                if (mdone) n_st = esc_pkg::t_seq'(r_st + 1'b1);
            esc_pkg::S_M8: n_st = esc_pkg::S_DIV0;
            esc_pkg::S_DIV0: n_st = (r_w1 == 64'd0) ? esc_pkg::S_H1 : esc_pkg::S_DIV;
            esc_pkg::S_DIV: if (ddone) n_st = esc_pkg::S_N1;
            esc_pkg::S_N4: n_st = esc_pkg::S_H1;
            esc_pkg::S_H8: n_st = esc_pkg::S_H9;
            esc_pkg::S_H9: n_st = esc_pkg::S_OUT;
            esc_pkg::S_OUT: if (!r_ov || i_ready) n_st = esc_pkg::S_IDLE;
            default: n_st = esc_pkg::S_IDLE;
        endcase
    end

    // Operand selection, start of each product and start of the division.
    always_comb begin
        mstart = 1'b0;
        ma = '0;
        mb = '0;
        dstart = (r_st == esc_pkg::S_DIV0) && (r_w1 != 64'd0);
        unique case (r_st)
            esc_pkg::S_M1: begin ma = r_w1; mb = r_w1; mstart = 1'b1; end
            esc_pkg::S_M2: begin
                ma = r_acc; mb = sx16(i_cf.press_b[31:16]); mstart = 1'b1;
            end
            esc_pkg::S_M3: begin
                ma = r_w1; mb = sx16(i_cf.press_b[15:0]); mstart = 1'b1;
            end
            esc_pkg::S_M4: begin
                ma = r_q; mb = sx16(i_cf.press_a[47:32]); mstart = 1'b1;
            end
            esc_pkg::S_M5: begin
                ma = r_w1; mb = sx16(i_cf.press_a[31:16]); mstart = 1'b1;
            end
            esc_pkg::S_M6: begin
                ma = r_x1; mb = {48'd0, i_cf.press_a[15:0]}; mstart = 1'b1;
            end
            esc_pkg::S_M7: begin ma = r_ww; mb = 64'd3125; mstart = 1'b1; end
            esc_pkg::S_N1: begin ma = r_q; mb = r_q; mstart = 1'b1; end
            esc_pkg::S_N2: begin
                ma = r_acc; mb = sx16(i_cf.hum_a[15:0]); mstart = 1'b1;
            end
            esc_pkg::S_N3: begin
                ma = r_p; mb = sx16(i_cf.press_b[63:48]); mstart = 1'b1;
            end
            esc_pkg::S_H1: begin
                ma = {{52{i_cf.hum_b[23]}}, i_cf.hum_b[23:12]}; mb = {32'd0, v};
                mstart = 1'b1;
            end
            esc_pkg::S_H2: begin
                ma = {32'd0, v}; mb = {{56{i_cf.hum_b[31]}}, i_cf.hum_b[31:24]};
                mstart = 1'b1;
            end
            esc_pkg::S_H3: begin
                ma = {32'd0, v}; mb = {56'd0, i_cf.hum_a[47:40]}; mstart = 1'b1;
            end
            esc_pkg::S_H4: begin ma = {32'd0, r_y}; mb = {32'd0, r_z}; mstart = 1'b1; end
            esc_pkg::S_H5: begin
                ma = {32'd0, r_z}; mb = sx16(i_cf.hum_a[39:24]); mstart = 1'b1;
            end
            esc_pkg::S_H6: begin ma = {32'd0, r_x}; mb = {32'd0, r_z}; mstart = 1'b1; end
            esc_pkg::S_H7: begin ma = {32'd0, r_r}; mb = {32'd0, r_r}; mstart = 1'b1; end
            default: ;
        endcase
        if (r_mbusy) mstart = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= esc_pkg::S_IDLE;
            r_mbusy <= 1'b0;
            r_mph   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_st <= n_st;
            if (mstart) begin
                r_mbusy <= 1'b1;
                r_mph   <= '0;
            end else if (r_mbusy) begin
                r_mph <= r_mph + 1'b1;
                if (r_mph == 2'd3) r_mbusy <= 1'b0;
            end
            if (r_st == esc_pkg::S_OUT && (!r_ov || i_ready)) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
        if (mstart) begin
            r_ma  <= ma;
            r_mb  <= mb;
            r_acc <= '0;
        end else if (r_mbusy) begin
            unique case (r_mph)
                2'd0: r_acc <= pp;
                2'd1, 2'd2: r_acc <= prod;
                default: r_acc <= prod;
            endcase
        end
        if (r_st == esc_pkg::S_IDLE && i_valid) begin
            r_tf  <= i_req.t_fine;
            r_adp <= i_req.raw_press;
            r_adh <= i_req.raw_hum;
            r_w1  <= {{32{i_req.t_fine[31]}}, i_req.t_fine} - 64'd128000;
        end
        if (mdone) begin
            unique case (r_st)
                esc_pkg::S_M1: r_q <= prod;
                esc_pkg::S_M2: r_w2 <= prod;
                esc_pkg::S_M3: r_w2 <= r_w2 + {prod[46:0], 17'd0} + {p4x[28:0], 35'd0};
                esc_pkg::S_M4: r_x1 <= asr64(prod, 8);
                esc_pkg::S_M5: begin
                    r_x1 <= 64'(64'h0000_8000_0000_0000 + r_x1 + {prod[51:0], 12'd0});
                    r_ww <= 64'({43'd0, 21'(21'h100000 - {1'b0, r_adp})} << 31) - r_w2;
                end
                esc_pkg::S_M6: r_w1 <= asr64(prod, 33);
                esc_pkg::S_M7: r_ww <= prod;
                esc_pkg::S_N1: r_x1 <= prod;
                esc_pkg::S_N2: r_x1 <= asr64(prod, 25);
                esc_pkg::S_N3: r_p <= asr64(r_p + r_x1 + asr64(prod, 19), 8)
                    + {p7x[59:0], 4'd0};
                esc_pkg::S_H1: r_x <= asr32(32'({r_adh, 14'd0}) - {i_cf.hum_b[11:0], 20'd0}
                    - prod[31:0] + 32'd16384, 15);
                esc_pkg::S_H2: r_y <= asr32(prod[31:0], 10);
                esc_pkg::S_H3: r_z <= asr32(prod[31:0], 11) + 32'd32768;
                esc_pkg::S_H4: r_z <= asr32(prod[31:0], 10) + 32'd2097152;
                esc_pkg::S_H5: r_z <= asr32(prod[31:0] + 32'd8192, 14);
                esc_pkg::S_H6: begin
                    r_hv <= prod[31:0];
                    r_r  <= asr32(prod[31:0], 15);
                end
                esc_pkg::S_H7: r_r <= prod[31:0];
                default: ;
            endcase
        end
        if (r_st == esc_pkg::S_DIV && ddone) begin
            r_p <= dquo;
            r_q <= asr64(dquo, 13);
        end
        if (r_st == esc_pkg::S_OUT && (!r_ov || i_ready)) begin
            r_out.temp_centi  <= tsat;
            r_out.press_valid <= (r_w1 != 64'd0);
            r_out.press_q8    <= (r_w1 != 64'd0) ? r_p[31:0] : 32'd0;
            r_out.hum_q10     <= hq;
        end
    end
    // The M1 product (w1*w1) also feeds M2 via r_acc while r_q keeps it for M4.
    // S_M8, S_N4, S_H8 and S_H9 are pass-through steps that move on unconditionally.
endmodule

FILE: src/env_sensor_compensation.sv
// env_sensor_compensation: top level of the sensor compensation block.
// Depends on esc_pkg, esc_front, esc_fifo and esc_back.
//
// Usage:
//   Raw measurement requests arrive on i_in_valid / o_in_ready with payload
//   i_in (raw temperature, pressure and humidity codes). Each one produces
//   exactly one result request on o_out_valid / i_out_ready with payload
//   o_out. The user must write the calibration registers through i_cfg_we,
//   i_cfg_idx and i_cfg_data only while the block is idle; the block itself
//   does not enforce this. Writes take effect immediately. The front part
//   forms the fine temperature in two pipeline stages and parks it in a
//   four-entry queue. The back part runs a sequencer around one shared
//   multiplier built from 32x32 partial products, where each product is
//   an operand load and then the partial products in turn, and around a
//   one-bit-per-cycle 64-bit divider. It chains seventeen products and the
//   division and handles one request at a time. Reset clears all
//   coefficients to zero and empties the pipeline. When the receiver
//   stalls, the finished result waits in the output register and the front
//   part keeps accepting until the queue and its own stages fill.
module env_sensor_compensation #(
    parameter int unsigned QDepth = esc_pkg::QDepth
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  esc_pkg::t_in_req             i_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output esc_pkg::t_out_req            o_out,
    input  logic                         i_cfg_we,
    input  logic [esc_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [esc_pkg::CfgDataW-1:0] i_cfg_data
);
    esc_pkg::t_coeffs  r_cf;
    esc_pkg::t_mid_req f_req, q_req;
    logic f_valid, f_ready, q_valid, q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cf <= '0;
        end else if (i_cfg_we) begin
            unique case (esc_pkg::t_cfg_idx'(i_cfg_idx))
                esc_pkg::CFG_TEMP:    r_cf.temp    <= i_cfg_data[47:0];
                esc_pkg::CFG_PRESS_A: r_cf.press_a <= i_cfg_data;
                esc_pkg::CFG_PRESS_B: r_cf.press_b <= i_cfg_data;
                esc_pkg::CFG_HUM_A:   r_cf.hum_a   <= i_cfg_data[47:0];
                esc_pkg::CFG_HUM_B:   r_cf.hum_b   <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    esc_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in_valid), .o_ready(o_in_ready), .i_req(i_in),
        .i_temp_coeffs(r_cf.temp),
        .o_valid(f_valid), .i_ready(f_ready), .o_req(f_req)
    );

    esc_fifo #(.Depth(QDepth)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_req(f_req),
        .o_valid(q_valid), .i_ready(q_ready), .o_req(q_req)
    );

    esc_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_req(q_req), .i_cf(r_cf),
        .o_valid(o_out_valid), .i_ready(i_out_ready), .o_req(o_out)
    );
endmodule

FILE: sim/tb.sv
// tb: self-checking testbench for env_sensor_compensation.
// Depends on esc_pkg and the block's RTL; drives directed rows, then random
// measurement sets, and checks each result against an in-bench predictor.
`timescale 1ns / 100ps

module tb;

    localparam int unsigned NumRandom = 550;
    localparam longint      CycleLimit = 2000000;
    localparam int          DrainWait = 400;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    esc_pkg::t_in_req    i_in;
    logic       o_out_valid;
    logic       i_out_ready;
    esc_pkg::t_out_req   o_out;
    logic       i_cfg_we;
    logic [esc_pkg::CfgIdxW-1:0]  i_cfg_idx;
    logic [esc_pkg::CfgDataW-1:0] i_cfg_data;

    env_sensor_compensation i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // The predictor's own copy of the calibration registers.
    logic [47:0] cal_temp;
    logic [63:0] cal_press_a;
    logic [63:0] cal_press_b;
    logic [47:0] cal_hum_a;
    logic [31:0] cal_hum_b;

    // Results still owed by the block, oldest first.
    esc_pkg::t_out_req pending_results[$];
    int       error_count = 0;
    longint   cycle_count = 0;
    bit       long_stall = 1'b0;

    // A directed row: the raw codes plus, where it is obvious, the result.
    typedef struct {
        esc_pkg::t_in_req  meas;
        bit                typed;
        esc_pkg::t_out_req result;
    } t_row;

    // Arithmetic shifts on plain bit vectors keep the wrap of the datapath.
    function automatic logic [31:0] asr32(logic [31:0] x, int n);
        return 32'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] x, int n);
        return 64'($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16(logic [15:0] x);
        return {{16{x[15]}}, x};
    endfunction

    function automatic logic [63:0] sx16w(logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    function automatic esc_pkg::t_out_req compensate(esc_pkg::t_in_req m);
        logic [31:0] adc_t, t1, t2, t3, a, b, v1, v2, tf;
        logic [63:0] tfs, tc, w1, w2, p, q, x1, x2, num, ua, ub, uq;
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6, v, x, y, z, w, r;
        longint      tcs, hv;
        esc_pkg::t_out_req res;
        adc_t = {12'd0, m.raw_temp};
        t1 = {16'd0, cal_temp[15:0]};
        t2 = sx16(cal_temp[31:16]);
        t3 = sx16(cal_temp[47:32]);
        a  = (adc_t >> 3) - (t1 << 1);
        v1 = asr32(a * t2, 11);
        b  = (adc_t >> 4) - t1;
        v2 = asr32(asr32(b * b, 12) * t3, 14);
        tf = v1 + v2;
        tfs = {{32{tf[31]}}, tf};
        tc  = asr64(tfs * 5 + 128, 8);
        tcs = $signed(tc);
        if (tcs > 32767) tcs = 32767;
        if (tcs < -32768) tcs = -32768;
        res.temp_centi = 16'(tcs);

        p1 = {48'd0, cal_press_a[15:0]};
        p2 = sx16w(cal_press_a[31:16]);
        p3 = sx16w(cal_press_a[47:32]);
        p4 = sx16w(cal_press_a[63:48]);
        p5 = sx16w(cal_press_b[15:0]);
        p6 = sx16w(cal_press_b[31:16]);
        p7 = sx16w(cal_press_b[47:32]);
        p8 = sx16w(cal_press_b[63:48]);
        p9 = sx16w(cal_hum_a[15:0]);
        w1 = tfs - 64'd128000;
        w2 = w1 * w1 * p6;
        w2 += (w1 * p5) << 17;
        w2 += p4 << 35;
        w1 = asr64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
        w1 = asr64(((64'd1 << 47) + w1) * p1, 33);
        if (w1 == 0) begin
            res.press_q8 = '0;
            res.press_valid = 1'b0;
        end else begin
            p = 64'd1048576 - {44'd0, m.raw_press};
            num = ((p << 31) - w2) * 64'd3125;
            // Signed division toward zero done on magnitudes, so that the
            // most negative dividend over minus one wraps as it should.
            ua = num[63] ? -num : num;
            ub = w1[63] ? -w1 : w1;
            uq = ua / ub;
            p = (num[63] != w1[63]) ? -uq : uq;
            q  = asr64(p, 13);
            x1 = asr64(p9 * q * q, 25);
            x2 = asr64(p8 * p, 19);
            p  = asr64(p + x1 + x2, 8) + (p7 << 4);
            res.press_q8 = p[31:0];
            res.press_valid = 1'b1;
        end

        h1 = {24'd0, cal_hum_a[23:16]};
        h2 = sx16(cal_hum_a[39:24]);
        h3 = {24'd0, cal_hum_a[47:40]};
        h4 = {{20{cal_hum_b[11]}}, cal_hum_b[11:0]};
        h5 = {{20{cal_hum_b[23]}}, cal_hum_b[23:12]};
        h6 = {{24{cal_hum_b[31]}}, cal_hum_b[31:24]};
        v = tf - 32'd76800;
        x = asr32(({16'd0, m.raw_hum} << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
        y = asr32(v * h6, 10);
        z = asr32(v * h3, 11) + 32'd32768;
        w = asr32(y * z, 10) + 32'd2097152;
        w = asr32(w * h2 + 32'd8192, 14);
        v = x * w;
        r = asr32(v, 15);
        v = v - asr32(asr32(r * r, 7) * h1, 4);
        hv = longint'($signed(v));
        if (hv < 0) hv = 0;
        if (hv > 419430400) hv = 419430400;
        res.hum_q10 = 17'(hv >> 12);
        return res;
    endfunction

    task automatic write_cal(esc_pkg::t_cfg_idx idx, logic [63:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            esc_pkg::CFG_TEMP:    cal_temp    = value[47:0];
            esc_pkg::CFG_PRESS_A: cal_press_a = value;
            esc_pkg::CFG_PRESS_B: cal_press_b = value;
            esc_pkg::CFG_HUM_A:   cal_hum_a   = value[47:0];
            esc_pkg::CFG_HUM_B:   cal_hum_b   = value[31:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all_cal(logic [47:0] t, logic [63:0] pa, logic [63:0] pb,
                                 logic [47:0] ha, logic [31:0] hb);
        write_cal(esc_pkg::CFG_TEMP, {16'd0, t});
        write_cal(esc_pkg::CFG_PRESS_A, pa);
        write_cal(esc_pkg::CFG_PRESS_B, pb);
        write_cal(esc_pkg::CFG_HUM_A, {16'd0, ha});
        write_cal(esc_pkg::CFG_HUM_B, {32'd0, hb});
    endtask

    // Stop offering, wait until every owed result has come, then let the
    // back part settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 4);
    endfunction

    // Valid stays high between back-to-back requests; it drops only for a gap
    // or when the sender waits for the block to drain.
    task automatic send_meas(esc_pkg::t_in_req m, bit use_gap);
        int g;
        g = use_gap ? gap_len() : 0;
        if (g != 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= m;
        pending_results.push_back(compensate(m));
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    function automatic esc_pkg::t_in_req rand_meas();
        esc_pkg::t_in_req m;
        m.raw_temp  = 20'($urandom);
        m.raw_press = 20'($urandom);
        m.raw_hum   = 16'($urandom);
        // Corner codes now and then so every bit sees both values.
        case ($urandom_range(0, 9))
            0: m.raw_temp  = $urandom_range(0, 1) ? '1 : '0;
            1: m.raw_press = $urandom_range(0, 1) ? '1 : '0;
            2: m.raw_hum   = $urandom_range(0, 1) ? '1 : '0;
            default: ;
        endcase
        return m;
    endfunction

    // A plausible calibration set, with random coefficients mixed in.
    task automatic random_cal();
        logic [47:0] t;
        logic [63:0] pa, pb;
        logic [47:0] ha;
        logic [31:0] hb;
        if ($urandom_range(0, 3) == 0) begin
            t  = {$urandom, $urandom};
            pa = {$urandom, $urandom};
            pb = {$urandom, $urandom};
            ha = {$urandom, $urandom};
            hb = $urandom;
        end else begin
            t  = {16'($signed(-16'd1000) + 16'($urandom_range(0, 2000))),
                  16'(26000 + $urandom_range(0, 2000)),
                  16'(27000 + $urandom_range(0, 2000))};
            pa = {16'(16'sd8000 + 16'($urandom_range(0, 2000))),
                  16'(3000 + $urandom_range(0, 2000)),
                  -16'(10000 + $urandom_range(0, 1000)),
                  16'(36000 + $urandom_range(0, 2000))};
            pb = {-16'(14000 + $urandom_range(0, 2000)),
                  16'(15000 + $urandom_range(0, 1000)),
                  -16'(7 + $urandom_range(0, 2)),
                  16'($urandom_range(0, 200))};
            ha = {8'd0, 16'(350 + $urandom_range(0, 50)),
                  8'($urandom_range(60, 90)), 16'(6000)};
            hb = {8'd30, 12'd50, 12'(300 + $urandom_range(0, 50))};
        end
        write_all_cal(t, pa, pb, ha, hb);
    endtask

    // Receiver: random stalls, plus one long hold-off of its own.
    initial begin
        int g;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (long_stall) begin
                i_out_ready <= 1'b0;
                repeat (1500) @(posedge i_clk);
                long_stall = 1'b0;
            end
            g = gap_len();
            if (g != 0) begin
                i_out_ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Result checker: compare every accepted result with the oldest owed one.
    always @(posedge i_clk) begin
        esc_pkg::t_out_req exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", o_out);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_out.temp_centi !== exp_res.temp_centi) begin
                    $error("temp_centi exp %0d got %0d", exp_res.temp_centi,
                           o_out.temp_centi);
                    error_count++;
                end
                if (o_out.press_q8 !== exp_res.press_q8) begin
                    $error("press_q8 exp %h got %h", exp_res.press_q8, o_out.press_q8);
                    error_count++;
                end
                if (o_out.press_valid !== exp_res.press_valid) begin
                    $error("press_valid exp %b got %b", exp_res.press_valid,
                           o_out.press_valid);
                    error_count++;
                end
                if (o_out.hum_q10 !== exp_res.hum_q10) begin
                    $error("hum_q10 exp %0d got %0d", exp_res.hum_q10, o_out.hum_q10);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_row row;
        esc_pkg::t_out_req typed_res;
        esc_pkg::t_in_req m;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = esc_pkg::CFG_TEMP;
        i_cfg_data = '0;
        cal_temp = '0; cal_press_a = '0; cal_press_b = '0;
        cal_hum_a = '0; cal_hum_b = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // All coefficients zero after reset: the fine temperature is zero, so
        // temperature reads 0 (128>>8), the pressure divisor is zero and
        // flags invalid, and the humidity product is zero.
        typed_res = '{hum_q10: '0, press_valid: 1'b0, press_q8: '0, temp_centi: 16'sd0};
        rows.push_back('{'{raw_hum: '0, raw_press: '0, raw_temp: '0}, 1'b1, typed_res});
        rows.push_back('{'{raw_hum: '1, raw_press: '1, raw_temp: '1}, 1'b1, typed_res});
        rows.push_back('{'{raw_hum: 16'h8000, raw_press: 20'h80000,
                           raw_temp: 20'h80000}, 1'b1, typed_res});
        foreach (rows[i]) begin
            row = rows[i];
            if (row.typed) begin
                // The typed result must agree with the predictor as well.
                if (compensate(row.meas) !== row.result) begin
                    $error("row %0d predictor %h typed %h", i, compensate(row.meas),
                           row.result);
                    error_count++;
                end
            end
            send_meas(row.meas, 1'b0);
        end
        wait_idle();

        // Typical calibration: extremes of the raw codes, then one typical measurement.
        write_all_cal({16'hFC18, 16'd26435, 16'd27504},
                      {16'd8000, 16'd2855, 16'hD5F3, 16'd36477},
                      {16'hC0FC, 16'd15500, 16'hFFF9, 16'd140},
                      {8'd0, 16'd366, 8'd75, 16'd6000},
                      {8'd30, 12'd50, 12'd324});
        rows.delete();
        for (int i = 0; i < 8; i++) begin
            m.raw_temp  = (i & 1) ? '1 : '0;
            m.raw_press = (i & 2) ? '1 : '0;
            m.raw_hum   = (i & 4) ? '1 : '0;
            send_meas(m, 1'b0);
        end
        send_meas('{raw_hum: 16'd30000, raw_press: 20'd415148, raw_temp: 20'd519888},
                  1'b0);
        wait_idle();

        // Extreme coefficients: all ones saturate and wrap the datapaths.
        write_all_cal('1, '1, '1, '1, '1);
        for (int i = 0; i < 4; i++) send_meas(rand_meas(), 1'b0);
        wait_idle();
        write_all_cal({16'h7FFF, 16'h8000, 16'hFFFF}, {4{16'h8000}}, {4{16'h7FFF}},
                      {8'hFF, 16'h7FFF, 8'hFF, 16'h8000}, {8'h80, 12'h800, 12'h7FF});
        for (int i = 0; i < 4; i++) send_meas(rand_meas(), 1'b0);
        wait_idle();

        // Random phases, each under its own calibration.
        for (int ph = 0; ph < 11; ph++) begin
            random_cal();
            if (ph == 3) long_stall = 1'b1;
            for (int i = 0; i < NumRandom / 11; i++) send_meas(rand_meas(), ph != 3);
            // The sender pauses here until every owed result has come.
            wait_idle();
        end

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
